// ===== hdl/nmel_pkg.sv =====
// nmel_pkg: shared widths, request and memory operation codes, and
// the memory operation and response structs of the nodal minimum edge length block.
// No dependencies.
package nmel_pkg;

   // field widths
   localparam int IDX_W        = 10;
   localparam int NODE_COUNT   = 1 << IDX_W;
   localparam int COORD_W      = 24;
   localparam int ABS_W        = COORD_W + 1;
   localparam int DIST_W       = 2 * ABS_W;
   localparam int LEN_W        = 25;
   localparam int TAG_W        = 4;
   localparam int WORD_W       = TAG_W + DIST_W;
   localparam int DRAIN_CYCLES = 3;

   // request codes
   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_NODE  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_RSVD  = 2'd3;

   // memory operation kinds
   localparam logic [1:0] OP_LOWER = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_SWEEP = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [1:0]        kind;
      logic [IDX_W-1:0]  addr;
      logic [DIST_W-1:0] sq_dist;
   } mem_op_type;

   typedef struct packed {
      logic              valid;
      logic              set;
      logic [DIST_W-1:0] value;
   } mem_rsp_type;

endpackage

// ===== hdl/nodal_min_edge_length_top.sv =====
// An element node is paired with each buffered node in turn, two table
// read-modify-writes per pair on one memory port. A read of a set node passes
// through the 25 step square root before its result beat. Every fifteenth clear
// and reset start a clearing pass over all 1024 node table entries, during
// which no beat is accepted.
// Reset is synchronous and active high. Depends on nmel_pkg and the nmel modules.
module nodal_min_edge_length_top #(
   parameter int MAX_ELEMENT_NODES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [nmel_pkg::IDX_W-1:0]          req_node_index,
   input  logic signed [nmel_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [nmel_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [nmel_pkg::COORD_W-1:0] req_coord_z,
   input  logic                                req_last_node,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [nmel_pkg::IDX_W-1:0]          rsp_read_index,
   output logic [nmel_pkg::LEN_W-1:0]          rsp_edge_length,
   output logic                                rsp_length_unset
);

   localparam int K_W   = (MAX_ELEMENT_NODES > 1) ? $clog2(MAX_ELEMENT_NODES) : 1;
   localparam int CNT_W = $clog2(MAX_ELEMENT_NODES + 1);
   localparam int DR_W  = $clog2(nmel_pkg::DRAIN_CYCLES);

   localparam logic [2:0] ST_SWEEP     = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_PAIR      = 3'd2;
   localparam logic [2:0] ST_DRAIN     = 3'd3;
   localparam logic [2:0] ST_FINISH    = 3'd4;
   localparam logic [2:0] ST_READ_WAIT = 3'd5;
   localparam logic [2:0] ST_SQRT      = 3'd6;
   localparam logic [2:0] ST_OUT       = 3'd7;

   // element buffer
   logic signed [nmel_pkg::COORD_W-1:0] buf_x_ff [MAX_ELEMENT_NODES];
   logic signed [nmel_pkg::COORD_W-1:0] buf_y_ff [MAX_ELEMENT_NODES];
   logic signed [nmel_pkg::COORD_W-1:0] buf_z_ff [MAX_ELEMENT_NODES];
   logic [nmel_pkg::IDX_W-1:0]          buf_id_ff [MAX_ELEMENT_NODES];

   logic [2:0]                          state_ff, state_in;
   logic [CNT_W-1:0]                    elem_count_ff, elem_count_in;
   logic [K_W-1:0]                      pair_k_ff, pair_k_in;
   logic                                phase_ff, phase_in;
   logic [DR_W-1:0]                     drain_ff, drain_in;
   logic [nmel_pkg::IDX_W-1:0]          sweep_addr_ff, sweep_addr_in;
   logic [nmel_pkg::TAG_W-1:0]          tag_ff, tag_in;
   logic [nmel_pkg::IDX_W-1:0]          cur_node_ff, cur_node_in;
   logic signed [nmel_pkg::COORD_W-1:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic                                cur_last_ff;
   logic                                unset_ff, unset_in;
   logic                                pend_valid_ff;
   logic [nmel_pkg::DIST_W-1:0]         pend_dist_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [nmel_pkg::IDX_W-1:0]          rsp_index_ff;
   logic [nmel_pkg::LEN_W-1:0]          rsp_length_ff;
   logic                                rsp_unset_ff;
   logic                                req_accept;
   logic                                node_latch;
   logic                                buf_write;
   logic                                out_load;
   logic                                sqrt_start;
   logic                                sqrt_done;
   logic [nmel_pkg::LEN_W-1:0]          sqrt_root;
   logic                                dist_valid;
   logic [nmel_pkg::DIST_W-1:0]         dist_value;
   logic [nmel_pkg::IDX_W-1:0]          dist_id;
   nmel_pkg::mem_op_type                mem_op;
   nmel_pkg::mem_rsp_type               mem_rsp;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;

   // pair distance pipeline
   nmel_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (state_ff == ST_PAIR && !phase_ff),
      .a_x       (cur_x_ff),
      .a_y       (cur_y_ff),
      .a_z       (cur_z_ff),
      .b_x       (buf_x_ff[pair_k_ff]),
      .b_y       (buf_y_ff[pair_k_ff]),
      .b_z       (buf_z_ff[pair_k_ff]),
      .in_id     (buf_id_ff[pair_k_ff]),
      .out_valid (dist_valid),
      .out_dist  (dist_value),
      .out_id    (dist_id)
   );

   // node minimum table
   nmel_min_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .op      (mem_op),
      .cur_tag (tag_ff),
      .rsp     (mem_rsp)
   );

   // square root of the stored minimum
   nmel_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (mem_rsp.value),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // table operation select: sweep, then read, then the buffered node, then the new node
   always_comb begin
      mem_op = '0;
      priority if (state_ff == ST_SWEEP) begin
         mem_op.valid = 1'b1;
         mem_op.kind  = nmel_pkg::OP_SWEEP;
         mem_op.addr  = sweep_addr_ff;
      end else if (req_accept && req_type == nmel_pkg::REQ_READ) begin
         mem_op.valid = 1'b1;
         mem_op.kind  = nmel_pkg::OP_READ;
         mem_op.addr  = req_node_index;
      end else if (dist_valid) begin
         mem_op.valid   = 1'b1;
         mem_op.kind    = nmel_pkg::OP_LOWER;
         mem_op.addr    = dist_id;
         mem_op.sq_dist = dist_value;
      end else if (pend_valid_ff) begin
         mem_op.valid   = 1'b1;
         mem_op.kind    = nmel_pkg::OP_LOWER;
         mem_op.addr    = cur_node_ff;
         mem_op.sq_dist = pend_dist_ff;
      end else begin
         mem_op = '0;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      elem_count_in = elem_count_ff;
      pair_k_in     = pair_k_ff;
      phase_in      = phase_ff;
      drain_in      = drain_ff;
      sweep_addr_in = sweep_addr_ff;
      tag_in        = tag_ff;
      cur_node_in   = cur_node_ff;
      unset_in      = unset_ff;
      node_latch    = 1'b0;
      buf_write     = 1'b0;
      out_load      = 1'b0;
      sqrt_start    = 1'b0;
      unique case (state_ff)
         ST_SWEEP: begin
            sweep_addr_in = sweep_addr_ff + nmel_pkg::IDX_W'(1);
            if (sweep_addr_ff == nmel_pkg::IDX_W'(nmel_pkg::NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               cur_node_in = req_node_index;
               unique case (req_type)
                  nmel_pkg::REQ_CLEAR: begin
                     elem_count_in = '0;
                     if (tag_ff == '1) begin
                        tag_in        = nmel_pkg::TAG_W'(1);
                        sweep_addr_in = '0;
                        state_in      = ST_SWEEP;
                     end else begin
                        tag_in = tag_ff + nmel_pkg::TAG_W'(1);
                     end
                  end
                  nmel_pkg::REQ_NODE: begin
                     node_latch = 1'b1;
                     pair_k_in  = '0;
                     phase_in   = 1'b0;
                     state_in   = (elem_count_ff == '0) ? ST_FINISH : ST_PAIR;
                  end
                  nmel_pkg::REQ_READ: begin
                     state_in = ST_READ_WAIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_PAIR: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (CNT_W'(pair_k_ff) == elem_count_ff - CNT_W'(1)) begin
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  pair_k_in = pair_k_ff + K_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + DR_W'(1);
            if (drain_ff == DR_W'(nmel_pkg::DRAIN_CYCLES - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (elem_count_ff < CNT_W'(MAX_ELEMENT_NODES)) begin
               buf_write     = 1'b1;
               elem_count_in = elem_count_ff + CNT_W'(1);
            end
            if (cur_last_ff) begin
               elem_count_in = '0;
            end
            state_in = ST_IDLE;
         end
         ST_READ_WAIT: begin
            if (mem_rsp.valid) begin
               unset_in = !mem_rsp.set;
               if (mem_rsp.set) begin
                  sqrt_start = 1'b1;
                  state_in   = ST_SQRT;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         tag_ff        <= nmel_pkg::TAG_W'(1);
         elem_count_ff <= '0;
         phase_ff      <= 1'b0;
         pair_k_ff     <= '0;
         drain_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         tag_ff        <= tag_in;
         elem_count_ff <= elem_count_in;
         phase_ff      <= phase_in;
         pair_k_ff     <= pair_k_in;
         drain_ff      <= drain_in;
         pend_valid_ff <= dist_valid;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers and element buffer
   always_ff @(posedge clock) begin
      cur_node_ff  <= cur_node_in;
      unset_ff     <= unset_in;
      pend_dist_ff <= dist_value;
      if (node_latch) begin
         cur_x_ff    <= req_coord_x;
         cur_y_ff    <= req_coord_y;
         cur_z_ff    <= req_coord_z;
         cur_last_ff <= req_last_node;
      end
      if (buf_write) begin
         buf_x_ff[elem_count_ff[K_W-1:0]]  <= cur_x_ff;
         buf_y_ff[elem_count_ff[K_W-1:0]]  <= cur_y_ff;
         buf_z_ff[elem_count_ff[K_W-1:0]]  <= cur_z_ff;
         buf_id_ff[elem_count_ff[K_W-1:0]] <= cur_node_ff;
      end
      if (out_load) begin
         rsp_index_ff  <= cur_node_ff;
         rsp_length_ff <= unset_ff ? '0 : sqrt_root;
         rsp_unset_ff  <= unset_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_index   = rsp_index_ff;
   assign rsp_edge_length  = rsp_length_ff;
   assign rsp_length_unset = rsp_unset_ff;

   // checks
   a_rsp_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      mem_rsp.valid |-> state_ff == ST_READ_WAIT)
      else $error("table read data arrived outside a read");

   a_sqrt_done_in_sqrt: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == ST_SQRT)
      else $error("square root finished outside its state");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      elem_count_ff <= CNT_W'(MAX_ELEMENT_NODES))
      else $error("element buffer count overflow");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && rsp_stall) |=> state_ff == ST_OUT)
      else $error("result overwrote an unread beat");

endmodule

// ===== hdl/nmel_dist.sv =====
// nmel_dist: three stage squared distance pipeline for one node pair.
// Depends on nmel_pkg.
module nmel_dist (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [nmel_pkg::COORD_W-1:0] a_x,
   input  logic signed [nmel_pkg::COORD_W-1:0] a_y,
   input  logic signed [nmel_pkg::COORD_W-1:0] a_z,
   input  logic signed [nmel_pkg::COORD_W-1:0] b_x,
   input  logic signed [nmel_pkg::COORD_W-1:0] b_y,
   input  logic signed [nmel_pkg::COORD_W-1:0] b_z,
   input  logic [nmel_pkg::IDX_W-1:0]          in_id,
   output logic                                out_valid,
   output logic [nmel_pkg::DIST_W-1:0]         out_dist,
   output logic [nmel_pkg::IDX_W-1:0]          out_id
);

   logic [2:0] valid_ff;
   logic [nmel_pkg::IDX_W-1:0] id1_ff, id2_ff, id3_ff;
   logic [nmel_pkg::ABS_W-1:0] ax_ff, ay_ff, az_ff;
   logic [nmel_pkg::DIST_W-1:0] sx_ff, sy_ff, sz_ff, sum_ff;
   logic signed [nmel_pkg::ABS_W-1:0] dx, dy, dz;

   // differences; magnitudes are taken in the first payload stage
   always_comb begin
      dx = nmel_pkg::ABS_W'(a_x) - nmel_pkg::ABS_W'(b_x);
      dy = nmel_pkg::ABS_W'(a_y) - nmel_pkg::ABS_W'(b_y);
      dz = nmel_pkg::ABS_W'(a_z) - nmel_pkg::ABS_W'(b_z);
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // payload stages: magnitude, square, sum
   always_ff @(posedge clock) begin
      ax_ff  <= dx[nmel_pkg::ABS_W-1] ? nmel_pkg::ABS_W'(-dx) : nmel_pkg::ABS_W'(dx);
      ay_ff  <= dy[nmel_pkg::ABS_W-1] ? nmel_pkg::ABS_W'(-dy) : nmel_pkg::ABS_W'(dy);
      az_ff  <= dz[nmel_pkg::ABS_W-1] ? nmel_pkg::ABS_W'(-dz) : nmel_pkg::ABS_W'(dz);
      id1_ff <= in_id;
      sx_ff  <= ax_ff * ax_ff;
      sy_ff  <= ay_ff * ay_ff;
      sz_ff  <= az_ff * az_ff;
      id2_ff <= id1_ff;
      sum_ff <= sx_ff + sy_ff + sz_ff;
      id3_ff <= id2_ff;
   end

   assign out_valid = valid_ff[2];
   assign out_dist  = sum_ff;
   assign out_id    = id3_ff;

endmodule

// ===== hdl/nmel_isqrt.sv =====
// nmel_isqrt: digit by digit floor square root, one result bit per cycle.
// Depends on nmel_pkg.
module nmel_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [nmel_pkg::DIST_W-1:0] value,
   output logic                        done,
   output logic [nmel_pkg::LEN_W-1:0]  root
);

   localparam int CNT_W = $clog2(nmel_pkg::LEN_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [nmel_pkg::DIST_W-1:0] val_ff, val_in;
   logic [nmel_pkg::LEN_W:0]    rem_ff, rem_in;
   logic [nmel_pkg::LEN_W-1:0]  root_ff, root_in;
   logic [nmel_pkg::LEN_W+2:0]  shifted, trial, diff;
   logic                        ge;
   logic                        last;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, val_ff[nmel_pkg::DIST_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = shifted >= trial;
      diff    = shifted - trial;
      last    = cnt_ff == CNT_W'(nmel_pkg::LEN_W - 1);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in  = {val_ff[nmel_pkg::DIST_W-3:0], 2'b00};
         rem_in  = ge ? diff[nmel_pkg::LEN_W:0] : shifted[nmel_pkg::LEN_W:0];
         root_in = {root_ff[nmel_pkg::LEN_W-2:0], ge};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== hdl/nmel_min_mem.sv =====
// nmel_min_mem: per node minimum table, tagged with a clear epoch, with a
// read-modify-write stage and forwarding of the last write. Depends on nmel_pkg.
module nmel_min_mem (
   input  logic                       clock,
   input  logic                       reset,
   input  nmel_pkg::mem_op_type       op,
   input  logic [nmel_pkg::TAG_W-1:0] cur_tag,
   output nmel_pkg::mem_rsp_type      rsp
);

   logic [nmel_pkg::WORD_W-1:0] min_mem_ff [nmel_pkg::NODE_COUNT];
   logic [nmel_pkg::WORD_W-1:0] rdata_ff;
   nmel_pkg::mem_op_type        s1_ff;
   logic                        last_wr_valid_ff;
   logic [nmel_pkg::IDX_W-1:0]  last_wr_addr_ff;
   logic [nmel_pkg::WORD_W-1:0] last_wr_data_ff;
   logic [nmel_pkg::WORD_W-1:0] word;
   logic [nmel_pkg::TAG_W-1:0]  word_tag;
   logic [nmel_pkg::DIST_W-1:0] word_val;
   logic                        word_set;
   logic                        wr_en;
   logic [nmel_pkg::WORD_W-1:0] wr_data;

   // forward the write that the read just missed
   always_comb begin
      word = (last_wr_valid_ff && last_wr_addr_ff == s1_ff.addr) ? last_wr_data_ff
                                                                 : rdata_ff;
      word_tag = word[nmel_pkg::WORD_W-1 -: nmel_pkg::TAG_W];
      word_val = word[nmel_pkg::DIST_W-1:0];
      word_set = word_tag == cur_tag;
      wr_en    = 1'b0;
      wr_data  = {cur_tag, s1_ff.sq_dist};
      unique case (s1_ff.kind)
         nmel_pkg::OP_LOWER: begin
            wr_en = s1_ff.valid && (!word_set || s1_ff.sq_dist < word_val);
         end
         nmel_pkg::OP_SWEEP: begin
            wr_en   = s1_ff.valid;
            wr_data = '0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign rsp.valid = s1_ff.valid && s1_ff.kind == nmel_pkg::OP_READ;
   assign rsp.set   = word_set;
   assign rsp.value = word_val;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         last_wr_valid_ff <= 1'b0;
      end else begin
         last_wr_valid_ff <= wr_en;
      end
   end

   // memory and operation stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= op.valid;
      end
      rdata_ff        <= min_mem_ff[op.addr];
      s1_ff.kind      <= op.kind;
      s1_ff.addr      <= op.addr;
      s1_ff.sq_dist   <= op.sq_dist;
      last_wr_addr_ff <= s1_ff.addr;
      last_wr_data_ff <= wr_data;
      if (wr_en) begin
         min_mem_ff[s1_ff.addr] <= wr_data;
      end
   end

endmodule

// ===== sim/nodal_min_edge_length_top_tb.sv =====
// Self-checking testbench for nodal_min_edge_length_top: random and directed element,
// clear and read beats, predicted per node and compared beat by beat.
// Depends on nmel_pkg and the nodal_min_edge_length_top RTL.
module nodal_min_edge_length_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ELEM_MAX = 8;
   localparam int WATCHDOG = 20000;

   typedef struct {
      logic [nmel_pkg::IDX_W-1:0] idx;
      logic [nmel_pkg::LEN_W-1:0] len;
      logic                       unset;
   } length_beat_type;

   // per-node shortest edge tracker and queue of pending length reports
   class min_edge_board;
      logic [63:0]          sq_min [nmel_pkg::NODE_COUNT];
      bit                   seen [nmel_pkg::NODE_COUNT];
      longint               ex [ELEM_MAX], ey [ELEM_MAX], ez [ELEM_MAX];
      int                   eid [ELEM_MAX];
      int                   ecount;
      length_beat_type      pending [$];
      int                   errors;
      int                   reads_checked;

      function void lower(int n, logic [63:0] d);
         if (!seen[n] || d < sq_min[n]) begin
            sq_min[n] = d;
            seen[n] = 1;
         end
      endfunction

      function logic [63:0] root(logic [63:0] v);
         logic [63:0] r;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            logic [63:0] t;
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      function void note_request(logic [1:0] kind, logic [nmel_pkg::IDX_W-1:0] idx,
                                 logic signed [nmel_pkg::COORD_W-1:0] x, y, z,
                                 logic last);
         length_beat_type b;
         logic [63:0]     d, r;
         longint          dx, dy, dz;
         if (kind == nmel_pkg::REQ_CLEAR) begin
            foreach (seen[i]) seen[i] = 0;
            ecount = 0;
         end else if (kind == nmel_pkg::REQ_NODE) begin
            for (int k = 0; k < ecount; k++) begin
               dx = longint'(x) - ex[k];
               dy = longint'(y) - ey[k];
               dz = longint'(z) - ez[k];
               d = dx * dx + dy * dy + dz * dz;
               lower(eid[k], d);
               lower(int'(idx), d);
            end
            if (ecount < ELEM_MAX) begin
               ex[ecount] = x; ey[ecount] = y; ez[ecount] = z; eid[ecount] = int'(idx);
               ecount++;
            end
            if (last) ecount = 0;
         end else if (kind == nmel_pkg::REQ_READ) begin
            b.idx = idx;
            if (seen[idx]) begin
               r = root(sq_min[idx]);
               b.len = (r > 64'h1FFFFFF) ? '1 : r[nmel_pkg::LEN_W-1:0];
               b.unset = 0;
            end else begin
               b.len = 0;
               b.unset = 1;
            end
            pending.push_back(b);
         end
      endfunction

      function void check_report(logic [nmel_pkg::IDX_W-1:0] idx,
                                 logic [nmel_pkg::LEN_W-1:0] len, logic unset);
         length_beat_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat idx=%0d len=%0d unset=%0d",
                     $realtime, idx, len, unset);
            errors++;
            return;
         end
         e = pending.pop_front();
         reads_checked++;
         if (idx !== e.idx) begin
            $display("%0t: read_index expected %0d actual %0d", $realtime, e.idx, idx);
            errors++;
         end
         if (len !== e.len) begin
            $display("%0t: edge_length expected %0d actual %0d", $realtime, e.len, len);
            errors++;
         end
         if (unset !== e.unset) begin
            $display("%0t: length_unset expected %0d actual %0d",
                     $realtime, e.unset, unset);
            errors++;
         end
      endfunction
   endclass

   logic                                clock = 0;
   logic                                reset = 1;
   logic                                req_valid = 0;
   logic                                req_stall;
   logic [1:0]                          req_type = nmel_pkg::REQ_CLEAR;
   logic [nmel_pkg::IDX_W-1:0]          req_node_index = '0;
   logic signed [nmel_pkg::COORD_W-1:0] req_coord_x = '0, req_coord_y = '0;
   logic signed [nmel_pkg::COORD_W-1:0] req_coord_z = '0;
   logic                                req_last_node = 0;
   logic                                rsp_valid;
   logic                                rsp_stall = 0;
   logic [nmel_pkg::IDX_W-1:0]          rsp_read_index;
   logic [nmel_pkg::LEN_W-1:0]          rsp_edge_length;
   logic                                rsp_length_unset;

   min_edge_board board = new();
   int  send_idle_pct = 17;
   int  recv_idle_pct = 84;
   bit  hold_rsp = 0;
   int  quiet_cycles = 0;
   int  beats_sent = 0;

   nodal_min_edge_length_top dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // result side: random stall, checking on accepted beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_report(rsp_read_index, rsp_edge_length, rsp_length_unset);
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("nodal_min_edge_length_top regression: fail");
         $finish;
      end
   end

   function automatic logic signed [nmel_pkg::COORD_W-1:0] rand_coord(int mode);
      case (mode)
         0: return 24'sh7FFFFF;
         1: return -24'sh800000;
         2: return nmel_pkg::COORD_W'($urandom);
         default: return nmel_pkg::COORD_W'($signed(12'($urandom)))
                         + nmel_pkg::COORD_W'(1000);
      endcase
   endfunction

   // offer one beat and hold it until accepted
   task automatic send_beat(logic [1:0] kind, logic [nmel_pkg::IDX_W-1:0] idx,
                            logic signed [nmel_pkg::COORD_W-1:0] x, y, z, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_type <= kind;
      req_node_index <= idx;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_last_node <= last;
      do @(posedge clock); while (req_stall);
      if (kind != nmel_pkg::REQ_RSVD) board.note_request(kind, idx, x, y, z, last);
      beats_sent++;
   endtask

   task automatic release_bus();
      req_valid <= 0;
      @(posedge clock);
   endtask

   // one element of random size, nodes drawn from indices 0 to pool; a small pool gives sharing
   task automatic send_element(int pool, int mode);
      int n;
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++)
         send_beat(nmel_pkg::REQ_NODE, nmel_pkg::IDX_W'($urandom_range(pool)),
                   rand_coord(mode), rand_coord(mode), rand_coord(mode), i == n - 1);
   endtask

   task automatic wait_drained();
      release_bus();
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      int r;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 55) send_element(63, $urandom_range(2, 3));
         else if (r < 60) send_element(1023, $urandom_range(0, 3));
         else if (r < 93)
            send_beat(nmel_pkg::REQ_READ, nmel_pkg::IDX_W'($urandom_range(63)),
                      '0, '0, '0, 1'b0);
         else if (r < 96)
            send_beat(nmel_pkg::REQ_READ, nmel_pkg::IDX_W'($urandom), '0, '0, '0, 1'b0);
         else if (r < 98)
            send_beat(nmel_pkg::REQ_CLEAR, nmel_pkg::IDX_W'($urandom), rand_coord(2),
                      rand_coord(2), rand_coord(2), 1'($urandom));
         else
            send_beat(nmel_pkg::REQ_RSVD, nmel_pkg::IDX_W'($urandom), rand_coord(2),
                      rand_coord(2), rand_coord(2), 1'($urandom));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: unset read, extremes, self pair, oversized element, reserved request, clear
      send_beat(nmel_pkg::REQ_READ, 10'd0, '0, '0, '0, 1'b0);
      send_beat(nmel_pkg::REQ_NODE, 10'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
      send_beat(nmel_pkg::REQ_NODE, 10'd1023, -24'sh800000, -24'sh800000, -24'sh800000,
                1'b1);
      send_beat(nmel_pkg::REQ_READ, 10'd0, '0, '0, '0, 1'b0);
      send_beat(nmel_pkg::REQ_READ, 10'd1023, '0, '0, '0, 1'b0);
      send_beat(nmel_pkg::REQ_NODE, 10'd5, 24'sd7, 24'sd7, 24'sd7, 1'b1);
      send_beat(nmel_pkg::REQ_READ, 10'd5, '0, '0, '0, 1'b0);
      for (int i = 0; i < 10; i++)
         send_beat(nmel_pkg::REQ_NODE, 10'(i + 20), 24'(i * 4096), 24'sd0, -24'(i * 3),
                   i == 9);
      send_beat(nmel_pkg::REQ_NODE, 10'd40, 24'sd100, 24'sd200, 24'sd300, 1'b0);
      send_beat(nmel_pkg::REQ_NODE, 10'd40, 24'sd100, 24'sd200, 24'sd300, 1'b1);
      send_beat(nmel_pkg::REQ_READ, 10'd29, '0, '0, '0, 1'b0);
      send_beat(nmel_pkg::REQ_READ, 10'd40, '0, '0, '0, 1'b0);
      send_beat(nmel_pkg::REQ_RSVD, 10'd40, '0, '0, '0, 1'b1);
      send_beat(nmel_pkg::REQ_CLEAR, 10'd0, '0, '0, '0, 1'b0);
      send_beat(nmel_pkg::REQ_READ, 10'd40, '0, '0, '0, 1'b0);

      // random with sender idling lightly, receiver heavily
      random_phase(110);
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      hold_rsp = 1;
      fork
         random_phase(30);
         begin repeat (400) @(posedge clock); hold_rsp = 0; end
      join
      wait_drained();

      send_idle_pct = 84;
      recv_idle_pct = 17;
      random_phase(110);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(130);
      wait_drained();

      repeat (60) @(posedge clock);
      $display("covered %0d request beats and %0d checked length reports",
               beats_sent, board.reads_checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("nodal_min_edge_length_top regression: pass");
      else
         $display("nodal_min_edge_length_top regression: fail");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/nmel_pkg.sv
hdl/nmel_dist.sv
hdl/nmel_isqrt.sv
hdl/nmel_min_mem.sv
hdl/nodal_min_edge_length_top.sv
sim/nodal_min_edge_length_top_tb.sv
